### hw/rtl/stepgen_pkg.sv
package stepgen_pkg;

  // Field widths
  localparam int unsigned NumAxes     = 5;
  localparam int unsigned StepWidth   = 31;
  localparam int unsigned DirWidth    = 5;
  localparam int unsigned PeriodWidth = 32;

  // Error accumulator width, legal range 8 to 32
  localparam int unsigned CountWidth = 32;
  // Width wide enough to compare an accumulator against the total
  localparam int unsigned CmpWidth = (CountWidth > StepWidth) ? CountWidth : StepWidth;

  // The C axis direction pin is driven inverted
  localparam int unsigned AxisC = 4;
  localparam logic [DirWidth-1:0] CDirInvert = DirWidth'(1 << AxisC);

  // Command queue between front and back
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QueuePtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  // One classified command as it travels through the queue
  typedef struct packed {
    op_e                                 op;
    logic [NumAxes-1:0][StepWidth-1:0]   steps;
    logic [StepWidth-1:0]                total;
    logic [CountWidth-1:0]               acc_init;
    logic [DirWidth-1:0]                 dirs;
    logic [PeriodWidth-1:0]              period;
  } cmd_t;

endpackage

### hw/rtl/stepgen_front.sv
module stepgen_front (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  output logic                                         in_stall_o,
  input  logic                                         operation_i,
  input  logic [stepgen_pkg::NumAxes-1:0][stepgen_pkg::StepWidth-1:0] steps_i,
  input  logic [stepgen_pkg::StepWidth-1:0]            total_steps_i,
  input  logic [stepgen_pkg::DirWidth-1:0]             directions_i,
  input  logic [stepgen_pkg::PeriodWidth-1:0]          period_in_i,
  output logic                                         push_o,
  output stepgen_pkg::cmd_t                            cmd_o,
  input  logic                                         queue_full_i
);

  logic              front_valid_q, front_valid_d;
  stepgen_pkg::cmd_t front_cmd_q, cmd_d;
  logic              take;

  // Transfer into the front stage whenever it is empty or draining
  assign in_stall_o = front_valid_q && queue_full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign push_o     = front_valid_q && !queue_full_i;
  assign cmd_o      = front_cmd_q;

  // Classify the item and precompute the initial error term
  always_comb begin
    cmd_d.op       = operation_i ? stepgen_pkg::OP_TICK : stepgen_pkg::OP_LOAD;
    cmd_d.steps    = steps_i;
    cmd_d.total    = total_steps_i;
    cmd_d.acc_init = stepgen_pkg::CountWidth'(total_steps_i >> 1);
    cmd_d.dirs     = directions_i;
    cmd_d.period   = period_in_i;
  end

  always_comb begin
    front_valid_d = front_valid_q;
    if (take) begin
      front_valid_d = 1'b1;
    end else if (push_o) begin
      front_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else begin
      front_valid_q <= front_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      front_cmd_q <= cmd_d;
    end
  end

endmodule

### hw/rtl/stepgen_fifo.sv
module stepgen_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  stepgen_pkg::cmd_t cmd_i,
  output logic              full_o,
  output logic              valid_o,
  output stepgen_pkg::cmd_t cmd_o,
  input  logic              pop_i
);

  stepgen_pkg::cmd_t                         mem_q [stepgen_pkg::QueueDepth];
  logic [stepgen_pkg::QueuePtrWidth-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [stepgen_pkg::QueueCntWidth-1:0]     count_q, count_d;
  logic                                      do_push, do_pop;

  assign full_o  = (count_q == stepgen_pkg::QueueCntWidth'(stepgen_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == stepgen_pkg::QueuePtrWidth'(stepgen_pkg::QueueDepth - 1))
               ? '0 : wr_ptr_q + stepgen_pkg::QueuePtrWidth'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == stepgen_pkg::QueuePtrWidth'(stepgen_pkg::QueueDepth - 1))
               ? '0 : rd_ptr_q + stepgen_pkg::QueuePtrWidth'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + stepgen_pkg::QueueCntWidth'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - stepgen_pkg::QueueCntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Occupancy never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= stepgen_pkg::QueueCntWidth'(stepgen_pkg::QueueDepth))
    else $error("queue count above depth");

endmodule

### hw/rtl/stepgen_back.sv
module stepgen_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cmd_valid_i,
  input  stepgen_pkg::cmd_t                    cmd_i,
  output logic                                 cmd_pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [stepgen_pkg::NumAxes-1:0]      step_pulses_o,
  output logic [stepgen_pkg::DirWidth-1:0]     dir_levels_o,
  output logic [stepgen_pkg::PeriodWidth-1:0]  tick_period_o,
  output logic                                 idle_o,
  output logic                                 block_done_o
);

  // Motion block state
  logic                                   active_q, active_d;
  logic [stepgen_pkg::CountWidth-1:0]     acc_q [stepgen_pkg::NumAxes];
  logic [stepgen_pkg::StepWidth-1:0]      steps_q [stepgen_pkg::NumAxes];
  logic [stepgen_pkg::StepWidth-1:0]      total_q;
  logic [stepgen_pkg::StepWidth-1:0]      events_q;
  logic [stepgen_pkg::DirWidth-1:0]       dir_q;
  logic [stepgen_pkg::PeriodWidth-1:0]    period_q;

  // Result register
  logic                                   out_valid_q, out_valid_d;
  logic [stepgen_pkg::NumAxes-1:0]        out_pulses_q;
  logic [stepgen_pkg::DirWidth-1:0]       out_dir_q;
  logic [stepgen_pkg::PeriodWidth-1:0]    out_period_q;
  logic                                   out_idle_q;
  logic                                   out_done_q;

  logic [stepgen_pkg::CmpWidth-1:0]       sum_w [stepgen_pkg::NumAxes];
  logic [stepgen_pkg::CountWidth-1:0]     acc_add [stepgen_pkg::NumAxes];
  logic [stepgen_pkg::CountWidth-1:0]     acc_next [stepgen_pkg::NumAxes];
  logic [stepgen_pkg::NumAxes-1:0]        pulse_vec;
  logic [stepgen_pkg::StepWidth-1:0]      events_next;
  logic                                   done_w;
  logic                                   is_load, is_tick, do_load, do_tick;

  // Loads never produce a result, so they drain even when the output is held
  assign cmd_pop_o = cmd_valid_i && (cmd_i.op == stepgen_pkg::OP_LOAD
                                     || !out_valid_q || !out_stall_i);
  assign is_load   = cmd_pop_o && (cmd_i.op == stepgen_pkg::OP_LOAD);
  assign is_tick   = cmd_pop_o && (cmd_i.op == stepgen_pkg::OP_TICK);
  assign do_load   = is_load && !active_q;
  assign do_tick   = is_tick && active_q;

  // Per-axis add, compare against total, subtract
  always_comb begin
    for (int i = 0; i < stepgen_pkg::NumAxes; i++) begin
      sum_w[i]     = stepgen_pkg::CmpWidth'(acc_q[i]) + stepgen_pkg::CmpWidth'(steps_q[i]);
      acc_add[i]   = stepgen_pkg::CountWidth'(sum_w[i]);
      pulse_vec[i] = stepgen_pkg::CmpWidth'(acc_add[i]) > stepgen_pkg::CmpWidth'(total_q);
      acc_next[i]  = pulse_vec[i] ? acc_add[i] - stepgen_pkg::CountWidth'(total_q)
                                  : acc_add[i];
    end
  end

  // Completed-event count and block end
  assign events_next = events_q + stepgen_pkg::StepWidth'(1);
  assign done_w      = (events_next >= total_q);

  always_comb begin
    active_d = active_q;
    if (do_load) begin
      active_d = 1'b1;
    end else if (do_tick && done_w) begin
      active_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (is_tick) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Block state update
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      for (int i = 0; i < stepgen_pkg::NumAxes; i++) begin
        acc_q[i]   <= cmd_i.acc_init;
        steps_q[i] <= cmd_i.steps[i];
      end
      total_q  <= cmd_i.total;
      events_q <= '0;
      dir_q    <= cmd_i.dirs;
      period_q <= cmd_i.period;
    end else if (do_tick) begin
      for (int i = 0; i < stepgen_pkg::NumAxes; i++) begin
        acc_q[i] <= acc_next[i];
      end
      events_q <= events_next;
    end
  end

  // Result capture; a tick with no block reports idle with zero fields
  always_ff @(posedge clk_i) begin
    if (is_tick) begin
      out_pulses_q <= active_q ? pulse_vec : '0;
      out_dir_q    <= active_q ? (dir_q ^ stepgen_pkg::CDirInvert) : '0;
      out_period_q <= active_q ? period_q : '0;
      out_idle_q   <= !active_q;
      out_done_q   <= active_q && done_w;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign step_pulses_o = out_pulses_q;
  assign dir_levels_o  = out_dir_q;
  assign tick_period_o = out_period_q;
  assign idle_o        = out_idle_q;
  assign block_done_o  = out_done_q;

  // A load taken while no block runs starts one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_load |=> active_q)
    else $error("load did not start a block");

  // The tick that finishes a block leaves the block inactive and reports done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_tick && done_w) |=> (!active_q && out_valid_q && out_done_q))
    else $error("block end not reflected");

  // An idle report carries no pulses and no done flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_idle_q) |-> (out_pulses_q == '0 && !out_done_q))
    else $error("idle result with activity");

endmodule

### hw/rtl/five_axis_bresenham_step_generator.sv
// Five-axis step generator (X, Y, Z, A, C) using Bresenham error accumulation. A load
// item (operation 0) stores a motion block if none is running and is silently dropped
// otherwise; it never produces a result. Each tick item (operation 1) produces exactly
// one result: the step pulses for that tick, the direction pin levels (C inverted), the
// block's tick period, and block_done on the tick that finishes the block, or idle = 1
// with all other fields zero when no block is loaded. The block sustains one item per
// clock in both directions while out_stall_i is low; a result passes the input register,
// the two-entry command queue and the output register on its way out. The per-tick
// cost is five parallel add, compare and subtract updates in the execute stage, which
// sets the clock limit. Loads drain from the queue even while a result is stalled at
// the output.
module five_axis_bresenham_step_generator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  operation_i,
  input  logic [stepgen_pkg::StepWidth-1:0]     steps_x_i,
  input  logic [stepgen_pkg::StepWidth-1:0]     steps_y_i,
  input  logic [stepgen_pkg::StepWidth-1:0]     steps_z_i,
  input  logic [stepgen_pkg::StepWidth-1:0]     steps_a_i,
  input  logic [stepgen_pkg::StepWidth-1:0]     steps_c_i,
  input  logic [stepgen_pkg::StepWidth-1:0]     total_steps_i,
  input  logic [stepgen_pkg::DirWidth-1:0]      directions_i,
  input  logic [stepgen_pkg::PeriodWidth-1:0]   period_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [stepgen_pkg::NumAxes-1:0]       step_pulses_o,
  output logic [stepgen_pkg::DirWidth-1:0]      dir_levels_o,
  output logic [stepgen_pkg::PeriodWidth-1:0]   tick_period_o,
  output logic                                  idle_o,
  output logic                                  block_done_o
);

  logic [stepgen_pkg::NumAxes-1:0][stepgen_pkg::StepWidth-1:0] steps_w;
  logic              push_w, full_w, q_valid_w, pop_w;
  stepgen_pkg::cmd_t front_cmd_w, q_cmd_w;

  assign steps_w = {steps_c_i, steps_a_i, steps_z_i, steps_y_i, steps_x_i};

  // Front: input stage and classification
  stepgen_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .steps_i       (steps_w),
    .total_steps_i (total_steps_i),
    .directions_i  (directions_i),
    .period_in_i   (period_in_i),
    .push_o        (push_w),
    .cmd_o         (front_cmd_w),
    .queue_full_i  (full_w)
  );

  // Command queue
  stepgen_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_w),
    .cmd_i   (front_cmd_w),
    .full_o  (full_w),
    .valid_o (q_valid_w),
    .cmd_o   (q_cmd_w),
    .pop_i   (pop_w)
  );

  // Back: block state, step computation and result register
  stepgen_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid_w),
    .cmd_i         (q_cmd_w),
    .cmd_pop_o     (pop_w),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .step_pulses_o (step_pulses_o),
    .dir_levels_o  (dir_levels_o),
    .tick_period_o (tick_period_o),
    .idle_o        (idle_o),
    .block_done_o  (block_done_o)
  );

endmodule
